// File: design/ppeu_pkg.sv
// Shared constants, codes and types for the particle pool update unit.
// No dependencies; imported by the top level and its port checker.
package ppeu_pkg;

  localparam int PARTICLES = 64;
  localparam int FRAC_BITS = 16;
  localparam int SLOT_W    = 6;
  localparam int COUNT_W   = 7;
  localparam int WORD_W    = 32;
  localparam int DT_W      = 16;
  localparam int IN_W      = 208;
  localparam int OUT_W     = 144;
  localparam int STATUS_W  = 2;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_ACCEL_X  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ACCEL_Y  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ACCEL_Z  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LIFETIME = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_SPAWNED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TICK    = 2'd2;

  localparam logic FUNC_SPAWN = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic [WORD_W-1:0] LIFETIME_RESET = WORD_W'(64'd2 << FRAC_BITS);

  typedef struct packed {
    logic [WORD_W-1:0]        age;
    logic [2:0][WORD_W-1:0]   vel;
    logic [2:0][WORD_W-1:0]   pos;
  } slot_t;

endpackage

// File: design/particle_pool_euler_update_unit.sv
// Particle pool with a free-slot stack and a shared saturating adder and multiplier.
// Depends on ppeu_pkg.
//
// A spawn item steps through accept, free-stack read, and slot write with result; a
// spawn into a full pool is answered from the free-stack check. A tick item visits
// each slot in turn: a dead slot is reported from the slot check, while a live slot
// is loaded and runs each axis through the one shared adder and multiplier (velocity
// add, multiply, truncation, position add), then the age add, then its write and
// result. A stall on the result side can hold the unit in place. Slot storage is a
// single-port-read memory with registered read data; no clearing pass follows reset.
module particle_pool_euler_update_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_step
  input  logic [ppeu_pkg::IN_W-1:0]         s_tdata,
  // func
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // slot, alive, out_pos_x, out_pos_y, out_pos_z, age, live_count, zero pad
  output logic [ppeu_pkg::OUT_W-1:0]        m_tdata,
  // status
  output logic [ppeu_pkg::STATUS_W-1:0]     m_tuser,
  output logic                              m_tlast,
  input  logic                              cfg_wen,
  input  logic [ppeu_pkg::REG_IDX_W-1:0]    cfg_idx,
  input  logic [ppeu_pkg::WORD_W-1:0]       cfg_data
);
  import ppeu_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SP_CHK  = 4'd1;
  localparam logic [3:0] S_SP_WR   = 4'd2;
  localparam logic [3:0] S_TK_SLOT = 4'd3;
  localparam logic [3:0] S_TK_LD   = 4'd4;
  localparam logic [3:0] S_VEL     = 4'd5;
  localparam logic [3:0] S_MUL     = 4'd6;
  localparam logic [3:0] S_QUO     = 4'd7;
  localparam logic [3:0] S_POS     = 4'd8;
  localparam logic [3:0] S_AGE     = 4'd9;
  localparam logic [3:0] S_TK_WR   = 4'd10;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PARTICLES - 1);

  logic [3:0]               state;
  logic [IN_W-1:0]          in_data;
  logic [2:0][WORD_W-1:0]   accel;
  logic [WORD_W-1:0]        lifetime;

  logic [PARTICLES-1:0]     alive_q;
  logic [COUNT_W-1:0]       free_count;
  logic [COUNT_W-1:0]       live_total;

  logic [SLOT_W-1:0]        stack_mem [PARTICLES];
  logic [PARTICLES-1:0]     stack_valid;
  logic [SLOT_W-1:0]        stack_rd;
  logic                     stack_rd_valid;
  logic [SLOT_W-1:0]        stack_rd_addr;

  slot_t                    slot_mem [PARTICLES];
  slot_t                    mem_rdata;
  slot_t                    mem_wdata;
  logic                     mem_we;
  logic [SLOT_W-1:0]        mem_waddr;

  slot_t                    cur;
  logic [SLOT_W-1:0]        slot_idx;
  logic [1:0]               axis;
  logic signed [49:0]       prod;
  logic [WORD_W-1:0]        quo;

  logic signed [49:0]       add_a;
  logic signed [49:0]       add_b;
  logic signed [49:0]       add_sum;
  logic [WORD_W-1:0]        sat_s;
  logic [WORD_W-1:0]        sat_u;
  logic signed [WORD_W-1:0] mul_a;
  logic signed [DT_W:0]     mul_b;
  logic signed [48:0]       mul_p;

  logic [DT_W-1:0]          dt;
  logic [WORD_W-1:0]        dage;
  logic                     out_free;
  logic                     out_load;
  logic [SLOT_W-1:0]        spawn_slot;
  logic                     dying;
  logic                     is_last;

  assign dt       = in_data[IN_W-1 -: DT_W];
  assign dage     = WORD_W'({24'd0, dt, 8'd0} >> (24 - FRAC_BITS));
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign spawn_slot = stack_rd_valid ? stack_rd : LAST_SLOT - stack_rd_addr;
  assign dying    = cur.age > lifetime;
  assign is_last  = (slot_idx == LAST_SLOT);

  function automatic logic signed [49:0] sext(input logic [WORD_W-1:0] v);
    sext = {{18{v[WORD_W-1]}}, v};
  endfunction

  // shared adder
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state)
      S_VEL: begin
        add_a = sext(cur.vel[axis]);
        add_b = sext(accel[axis]);
      end
      S_QUO: begin
        add_a = prod;
        add_b = prod[49] ? 50'sd65535 : 50'sd0;
      end
      S_POS: begin
        add_a = sext(cur.pos[axis]);
        add_b = sext(quo);
      end
      S_AGE: begin
        add_a = {18'd0, cur.age};
        add_b = {18'd0, dage};
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
    add_sum = add_a + add_b;
    if (add_sum > 50'sd2147483647) begin
      sat_s = 32'h7fff_ffff;
    end else if (add_sum < -50'sd2147483648) begin
      sat_s = 32'h8000_0000;
    end else begin
      sat_s = add_sum[WORD_W-1:0];
    end
    sat_u = (add_sum[49:WORD_W] != '0) ? '1 : add_sum[WORD_W-1:0];
  end

  // shared multiplier
  assign mul_a = cur.vel[axis];
  assign mul_b = {1'b0, dt};
  assign mul_p = mul_a * mul_b;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_idx;
    mem_wdata = cur;
    case (state)
      S_SP_WR: begin
        mem_we        = out_free;
        mem_waddr     = spawn_slot;
        mem_wdata.pos = in_data[3*WORD_W-1:0];
        mem_wdata.vel = in_data[6*WORD_W-1:3*WORD_W];
        mem_wdata.age = '0;
      end
      S_TK_WR: begin
        mem_we = out_free;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_SP_CHK:  out_load = out_free && (free_count == '0);
      S_SP_WR:   out_load = out_free;
      S_TK_SLOT: out_load = out_free && !alive_q[slot_idx];
      S_TK_WR:   out_load = out_free;
      default:   out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (state == S_TK_SLOT) begin
      mem_rdata <= slot_mem[slot_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accel    <= '0;
      lifetime <= LIFETIME_RESET;
    end else if (cfg_wen) begin
      case (cfg_idx)
        REG_ACCEL_X:  accel[0] <= cfg_data;
        REG_ACCEL_Y:  accel[1] <= cfg_data;
        REG_ACCEL_Z:  accel[2] <= cfg_data;
        REG_LIFETIME: lifetime <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      alive_q     <= '0;
      free_count  <= COUNT_W'(PARTICLES);
      live_total  <= '0;
      stack_valid <= '0;
      slot_idx    <= '0;
      axis        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_data  <= s_tdata;
            slot_idx <= '0;
            state    <= (s_tuser == FUNC_TICK) ? S_TK_SLOT : S_SP_CHK;
          end
        end
        S_SP_CHK: begin
          if (free_count == '0) begin
            if (out_free) begin
              m_tuser  <= STATUS_FULL;
              m_tlast  <= 1'b1;
              m_tdata  <= {2'b00, live_total, {(4*WORD_W+SLOT_W+1){1'b0}}};
              state    <= S_IDLE;
            end
          end else begin
            stack_rd       <= stack_mem[SLOT_W'(free_count - 1'b1)];
            stack_rd_valid <= stack_valid[SLOT_W'(free_count - 1'b1)];
            stack_rd_addr  <= SLOT_W'(free_count - 1'b1);
            free_count     <= free_count - 1'b1;
            state          <= S_SP_WR;
          end
        end
        S_SP_WR: begin
          if (out_free) begin
            alive_q[spawn_slot] <= 1'b1;
            m_tuser  <= STATUS_SPAWNED;
            m_tlast  <= 1'b1;
            if (!alive_q[spawn_slot]) begin
              live_total <= live_total + 1'b1;
              m_tdata <= {2'b00, live_total + 1'b1, {WORD_W{1'b0}},
                          in_data[3*WORD_W-1:0], 1'b1, spawn_slot};
            end else begin
              m_tdata <= {2'b00, live_total, {WORD_W{1'b0}},
                          in_data[3*WORD_W-1:0], 1'b1, spawn_slot};
            end
            state <= S_IDLE;
          end
        end
        S_TK_SLOT: begin
          if (alive_q[slot_idx]) begin
            state <= S_TK_LD;
          end else if (out_free) begin
            m_tuser  <= STATUS_TICK;
            m_tlast  <= is_last;
            m_tdata  <= {2'b00, live_total, {(4*WORD_W+1){1'b0}}, slot_idx};
            slot_idx <= slot_idx + 1'b1;
            if (is_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_TK_LD: begin
          cur   <= mem_rdata;
          axis  <= '0;
          state <= S_VEL;
        end
        S_VEL: begin
          cur.vel[axis] <= sat_s;
          state         <= S_MUL;
        end
        S_MUL: begin
          prod  <= {mul_p[48], mul_p};
          state <= S_QUO;
        end
        S_QUO: begin
          quo   <= add_sum[16 +: WORD_W];
          state <= S_POS;
        end
        S_POS: begin
          cur.pos[axis] <= sat_s;
          if (axis == 2'd2) begin
            state <= S_AGE;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_VEL;
          end
        end
        S_AGE: begin
          cur.age <= sat_u;
          state   <= S_TK_WR;
        end
        S_TK_WR: begin
          if (out_free) begin
            m_tuser  <= STATUS_TICK;
            m_tlast  <= is_last;
            if (dying) begin
              alive_q[slot_idx] <= 1'b0;
              if (free_count < COUNT_W'(PARTICLES)) begin
                stack_mem[SLOT_W'(free_count)]   <= slot_idx;
                stack_valid[SLOT_W'(free_count)] <= 1'b1;
                free_count <= free_count + 1'b1;
              end
              if (live_total != '0) begin
                live_total <= live_total - 1'b1;
                m_tdata <= {2'b00, live_total - 1'b1, cur.age, cur.pos, 1'b0, slot_idx};
              end else begin
                m_tdata <= {2'b00, live_total, cur.age, cur.pos, 1'b0, slot_idx};
              end
            end else begin
              m_tdata <= {2'b00, live_total, cur.age, cur.pos, 1'b1, slot_idx};
            end
            slot_idx <= slot_idx + 1'b1;
            state    <= is_last ? S_IDLE : S_TK_SLOT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/ppeu_checker.sv
// Port-level checks for the particle pool update unit, bound to its top level.
// Depends on ppeu_pkg and particle_pool_euler_update_unit.
module ppeu_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [ppeu_pkg::OUT_W-1:0]        m_tdata,
  input  logic [ppeu_pkg::STATUS_W-1:0]     m_tuser,
  input  logic                              m_tlast
);
  import ppeu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while previous item in progress");

  a_spawn_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != STATUS_TICK |-> m_tlast)
    else $error("spawn result not marked last");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STATUS_FULL |-> m_tdata[SLOT_W:0] == '0)
    else $error("pool full result carries a slot");

endmodule

bind particle_pool_euler_update_unit ppeu_checker u_ppeu_checker (.*);

// File: dv/tb.sv
// Self-checking testbench for particle_pool_euler_update_unit: spawn and tick items
// in, slot reports out, each compared with a cycle-free pool predictor held here.
// Depends on ppeu_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb;
  import ppeu_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;

  typedef struct packed {
    logic [DT_W-1:0]          dt;
    logic [2:0][WORD_W-1:0]   vel;
    logic [2:0][WORD_W-1:0]   pos;
  } particle_in_t;

  typedef struct packed {
    logic         func;
    particle_in_t body;
  } pool_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]        slot;
    logic [STATUS_W-1:0]      status;
    logic                     alive;
    logic [2:0][WORD_W-1:0]   pos;
    logic [WORD_W-1:0]        age;
    logic [COUNT_W-1:0]       live;
    logic                     last;
  } slot_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic [STATUS_W-1:0]   m_tuser;
  logic                  m_tlast;
  logic                  cfg_wen = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_idx = '0;
  logic [WORD_W-1:0]     cfg_data = '0;

  particle_pool_euler_update_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_wen  (cfg_wen),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  pool_item_t   items_to_send[$];
  slot_report_t reports_due[$];
  int           errors = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           hold_phase = 1'b0;
  int           quiet_cycles = 0;

  // predictor state
  logic [WORD_W-1:0] accel_reg [3];
  logic [WORD_W-1:0] life_limit;
  logic [WORD_W-1:0] part_pos [PARTICLES][3];
  logic [WORD_W-1:0] part_vel [PARTICLES][3];
  logic [WORD_W-1:0] part_age [PARTICLES];
  bit                part_alive [PARTICLES];
  logic [SLOT_W-1:0] free_slots [PARTICLES];
  int                free_n;
  int                live_n;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void queue_item(pool_item_t it);
    items_to_send = {items_to_send, it};
  endfunction

  function automatic logic [WORD_W-1:0] sat_word(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic void reset_pool_model();
    for (int a = 0; a < 3; a++) accel_reg[a] = '0;
    life_limit = LIFETIME_RESET;
    for (int i = 0; i < PARTICLES; i++) begin
      part_alive[i] = 1'b0;
      free_slots[i] = SLOT_W'(PARTICLES - 1 - i);
    end
    free_n = PARTICLES;
    live_n = 0;
  endfunction

  function automatic void predict_reports(pool_item_t it);
    slot_report_t      r;
    logic [SLOT_W-1:0] s;
    logic [WORD_W:0]   age_sum;
    logic [WORD_W-1:0] nv;
    longint            prod;
    if (it.func == FUNC_SPAWN) begin
      r = '0;
      r.last = 1'b1;
      if (free_n == 0) begin
        r.status = STATUS_FULL;
      end else begin
        free_n--;
        s = free_slots[free_n];
        for (int a = 0; a < 3; a++) begin
          part_pos[s][a] = it.body.pos[a];
          part_vel[s][a] = it.body.vel[a];
          r.pos[a] = it.body.pos[a];
        end
        part_age[s] = '0;
        if (!part_alive[s]) begin
          part_alive[s] = 1'b1;
          live_n++;
        end
        r.slot = s;
        r.status = STATUS_SPAWNED;
        r.alive = 1'b1;
      end
      r.live = COUNT_W'(live_n);
      reports_due = {reports_due, r};
    end else begin
      for (int i = 0; i < PARTICLES; i++) begin
        r = '0;
        r.slot = SLOT_W'(i);
        r.status = STATUS_TICK;
        r.last = (i == PARTICLES - 1);
        if (part_alive[i]) begin
          for (int a = 0; a < 3; a++) begin
            nv = sat_word(longint'($signed(part_vel[i][a])) +
                          longint'($signed(accel_reg[a])));
            part_vel[i][a] = nv;
            prod = (longint'($signed(nv)) * longint'(it.body.dt)) / 65536;
            part_pos[i][a] = sat_word(longint'($signed(part_pos[i][a])) + prod);
            r.pos[a] = part_pos[i][a];
          end
          age_sum = {1'b0, part_age[i]} + ((WORD_W + 1)'(it.body.dt) << (FRAC_BITS - 16));
          part_age[i] = age_sum[WORD_W] ? '1 : age_sum[WORD_W-1:0];
          if (part_age[i] > life_limit) begin
            part_alive[i] = 1'b0;
            if (free_n < PARTICLES) begin
              free_slots[free_n] = SLOT_W'(i);
              free_n++;
            end
            live_n--;
          end
          r.alive = part_alive[i];
          r.age = part_age[i];
        end
        r.live = COUNT_W'(live_n);
        reports_due = {reports_due, r};
      end
    end
  endfunction

  function automatic void compare_field(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_report();
    slot_report_t got;
    slot_report_t want;
    got.slot   = m_tdata[5:0];
    got.alive  = m_tdata[6];
    got.pos[0] = m_tdata[38:7];
    got.pos[1] = m_tdata[70:39];
    got.pos[2] = m_tdata[102:71];
    got.age    = m_tdata[134:103];
    got.live   = m_tdata[141:135];
    got.status = m_tuser;
    got.last   = m_tlast;
    if (reports_due.size() == 0) begin
      $error("unexpected report for slot %0d, status %0d", got.slot, got.status);
      errors++;
    end else begin
      want = reports_due.pop_front();
      compare_field("slot", want.slot, got.slot);
      compare_field("status", want.status, got.status);
      compare_field("alive", want.alive, got.alive);
      compare_field("out_pos_x", want.pos[0], got.pos[0]);
      compare_field("out_pos_y", want.pos[1], got.pos[1]);
      compare_field("out_pos_z", want.pos[2], got.pos[2]);
      compare_field("age", want.age, got.age);
      compare_field("live_count", want.live, got.live);
      compare_field("last", want.last, got.last);
    end
  endfunction

  // driver: hold the offered item until it is accepted
  pool_item_t offer;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_reports(offer);
      if (!s_tvalid || s_tready) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offer = items_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= offer.body;
          s_tuser <= offer.func;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check reports, stall at random, one long hold-off
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_report();
      if (hold_phase && !hold_done && s_tvalid && s_tready) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** particle_pool_euler_update_unit: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    case (idx)
      REG_ACCEL_X:  accel_reg[0] = value;
      REG_ACCEL_Y:  accel_reg[1] = value;
      REG_ACCEL_Z:  accel_reg[2] = value;
      REG_LIFETIME: life_limit = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic set_config(logic [WORD_W-1:0] ax, logic [WORD_W-1:0] ay,
                            logic [WORD_W-1:0] az, logic [WORD_W-1:0] life);
    write_reg(REG_ACCEL_X, ax);
    write_reg(REG_ACCEL_Y, ay);
    write_reg(REG_ACCEL_Z, az);
    write_reg(REG_LIFETIME, life);
  endtask

  task automatic wait_for_drain();
    do @(negedge clk);
    while (items_to_send.size() != 0 || s_tvalid || reports_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic pool_item_t random_item(int tick_pct);
    pool_item_t        r;
    logic [WORD_W-1:0] w;
    r.func = ($urandom_range(99) < tick_pct) ? FUNC_TICK : FUNC_SPAWN;
    for (int a = 0; a < 3; a++) begin
      r.body.pos[a] = $urandom();
      w = $urandom();
      if ($urandom_range(1)) w = {{12{w[19]}}, w[19:0]};
      r.body.vel[a] = w;
    end
    r.body.dt = DT_W'($urandom());
    return r;
  endfunction

  function automatic pool_item_t spawn_item(logic [WORD_W-1:0] p, logic [WORD_W-1:0] v);
    pool_item_t r;
    r = random_item(0);
    for (int a = 0; a < 3; a++) begin
      r.body.pos[a] = p;
      r.body.vel[a] = v;
    end
    return r;
  endfunction

  function automatic pool_item_t tick_item(logic [DT_W-1:0] dt);
    pool_item_t r;
    r = random_item(100);
    r.body.dt = dt;
    return r;
  endfunction

  initial begin
    reset_pool_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pool, extremes, truncation toward zero, aging to death
    set_config('0, '0, '0, LIFETIME_RESET);
    queue_item(random_item(100));
    queue_item(spawn_item(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    queue_item(spawn_item(32'h8000_0000, 32'h8000_0000));
    queue_item(spawn_item('0, 32'hFFFF_FFFF));
    queue_item(spawn_item($urandom(), 32'h0000_0001));
    queue_item(tick_item(16'hFFFF));
    queue_item(tick_item(16'h0000));
    queue_item(tick_item(16'h0001));
    queue_item(tick_item(16'hFFFF));
    queue_item(tick_item(16'hFFFF));
    repeat (3) queue_item(random_item(0));
    queue_item(random_item(100));
    wait_for_drain();

    // velocity saturation, sender idling
    set_config(32'h7FFF_FFFF, 32'h8000_0000, $urandom(), 32'hFFFF_FFFF);
    send_idle_pct = 61;
    repeat (25) queue_item(random_item(20));
    wait_for_drain();

    // fill the pool past full under receiver stalls and one long hold-off
    set_config($urandom(), $urandom(), $urandom(), 32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_stall_pct = 61;
    hold_phase = 1'b1;
    repeat (45) queue_item(random_item(0));
    repeat (5) queue_item(random_item(100));
    wait_for_drain();
    hold_phase = 1'b0;

    // short lifetimes: mass deaths and slot reuse
    set_config('0, {{12{1'b0}}, 20'($urandom())}, $urandom(), $urandom_range(300000));
    send_idle_pct = 8;
    recv_stall_pct = 8;
    repeat (25) queue_item(random_item(40));
    wait_for_drain();

    set_config(32'h8000_0000, 32'h7FFF_FFFF, '0, '0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) queue_item(random_item(30));
    wait_for_drain();

    repeat (20) @(posedge clk);
    if (errors == 0 && reports_due.size() == 0) begin
      $display("** particle_pool_euler_update_unit: PASSED **");
    end else begin
      $display("** particle_pool_euler_update_unit: FAILED **");
    end
    $finish;
  end

endmodule
